/* hw/rtl/bsa_pkg.sv */
// Shared constants, payload types and control structs for the bitmap sector allocator.
`timescale 1ns / 1ps

package bsa_pkg;

   localparam int SECTORS     = 1024;
   localparam int SECTOR_SIZE = 4096;
   localparam int SECTOR_SHIFT = $clog2(SECTOR_SIZE);

   localparam int WORD_W  = 8;
   localparam int WB_W    = $clog2(WORD_W);
   localparam int WORDS   = SECTORS / WORD_W;
   localparam int WORD_AW = $clog2(WORDS);
   localparam int IDX_W   = $clog2(SECTORS);

   localparam int ADDR_W = 32;
   localparam int CNT_W  = 11;
   localparam int LEN_W  = 11;
   localparam int LIM_W  = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

   localparam logic [WORD_W-1:0] ALL_FREE = 8'hFF;
   localparam logic [CNT_W-1:0]  SECTOR_COUNT_RESET = 11'd1024;

   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_FREE  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   localparam logic CSR_BASE  = 1'b0;
   localparam logic CSR_COUNT = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic [1:0]        action;
      logic [LEN_W-1:0]  run_length;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] granted_address;
      logic              status;
   } rsp_type;

   typedef struct packed {
      logic               rd_en;
      logic [WORD_AW-1:0] rd_addr;
      logic               wr_en;
      logic [WORD_AW-1:0] wr_addr;
      logic [WORD_W-1:0]  wr_data;
      logic               clear;
   } ram_ctl_type;

   typedef struct packed {
      logic              found;
      logic [IDX_W-1:0]  end_idx;
      logic [LEN_W-1:0]  run;
   } scan_res_type;

endpackage

/* hw/rtl/bitmap_sector_allocator.sv */
// Top level of the bitmap sector allocator: control sequencer, registers and result stage.
`timescale 1ns / 1ps

// First-fit sector allocator over a free map of one bit per sector (1 = free).
// Request channel (req_valid/req_stall/req_data) carries allocate, free and
// clear requests; every request yields exactly one beat on the result channel
// (rsp_valid/rsp_stall/rsp_data) with the granted address and a status bit.
// One request is worked at a time; req_stall is high while it is in flight.
// The map lives in a memory of 8-bit words with a registered read.
//   Allocate: scans map words in order until the run closes, then visits
//   each word the run spans to mark it used, then gives the result.
//   The scan covers up to 128 map words for a 1024-sector map.
//   Free: read, modify-write, result. Clear: goes straight to the result.
// A finished result waits in the result register while rsp_stall is high;
// the next request is accepted meanwhile but its result holds until the
// register drains. Reset marks all sectors free at once through per-word valid bits,
// sets base_address to 0 and sector_count to 1024. The user must write registers through
// csr_wr_en/csr_index/csr_wr_data only while no request is open; it is not enforced.

module bitmap_sector_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  bsa_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bsa_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [bsa_pkg::ADDR_W-1:0]  csr_wr_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_MARK = 3'd2;
   localparam logic [2:0] S_FREE = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [bsa_pkg::ADDR_W-1:0]    base_ff, base_in;
   logic [bsa_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [bsa_pkg::LEN_W-1:0]     len_ff, len_in;
   logic [bsa_pkg::LEN_W-1:0]     run_ff, run_in;
   logic [bsa_pkg::WORD_AW-1:0]   scan_wd_ff, scan_wd_in;
   logic [bsa_pkg::IDX_W-1:0]     start_ff, start_in;
   logic [bsa_pkg::IDX_W-1:0]     end_ff, end_in;
   logic [bsa_pkg::WORD_AW-1:0]   mk_wd_ff, mk_wd_in;
   logic [bsa_pkg::WORD_AW-1:0]   fr_wd_ff, fr_wd_in;
   logic [bsa_pkg::WB_W-1:0]      fr_bit_ff, fr_bit_in;
   bsa_pkg::rsp_type              pend_ff, pend_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   bsa_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic [bsa_pkg::LIM_W-1:0]     limit;
   logic [bsa_pkg::WORD_AW-1:0]   last_wd;
   logic [bsa_pkg::LIM_W-1:0]     limit_m1;
   logic [bsa_pkg::LIM_W-1:0]     st_wide;
   logic [bsa_pkg::ADDR_W-1:0]    offset;
   logic [bsa_pkg::ADDR_W-1:0]    free_idx;
   logic                          req_beat;
   logic [bsa_pkg::WORD_W-1:0]    rd_word;
   logic [bsa_pkg::WORD_W-1:0]    mark_mask;
   logic [bsa_pkg::IDX_W-1:0]     mk_bit_idx;
   bsa_pkg::ram_ctl_type          ctl;
   bsa_pkg::scan_res_type         scan_res;

   bsa_map_ram u_map_ram (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_word (rd_word)
   );

   bsa_run_scan u_run_scan (
      .word     (rd_word),
      .word_idx (scan_wd_ff),
      .run_in   (run_ff),
      .len      (len_ff),
      .limit    (limit),
      .res      (scan_res)
   );

   assign limit = (bsa_pkg::LIM_W'(count_ff) < bsa_pkg::LIM_W'(bsa_pkg::SECTORS)) ?
                  bsa_pkg::LIM_W'(count_ff) : bsa_pkg::LIM_W'(bsa_pkg::SECTORS);
   assign limit_m1 = limit - bsa_pkg::LIM_W'(1);
   assign last_wd  = limit_m1[bsa_pkg::IDX_W-1:bsa_pkg::WB_W];
   assign st_wide  = bsa_pkg::LIM_W'(scan_res.end_idx) + bsa_pkg::LIM_W'(1) -
                     bsa_pkg::LIM_W'(len_ff);
   assign offset   = req_data.address - base_ff;
   assign free_idx = offset >> bsa_pkg::SECTOR_SHIFT;
   assign req_beat = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      for (int k = 0; k < bsa_pkg::WORD_W; k++) begin
         mk_bit_idx   = {mk_wd_ff, bsa_pkg::WB_W'(k)};
         mark_mask[k] = (mk_bit_idx >= start_ff) && (mk_bit_idx <= end_ff);
      end
   end

   always_comb begin
      base_in  = base_ff;
      count_in = count_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bsa_pkg::CSR_BASE:  base_in  = csr_wr_data;
            bsa_pkg::CSR_COUNT: count_in = csr_wr_data[bsa_pkg::CNT_W-1:0];
            default:            base_in  = base_ff;
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      run_in     = run_ff;
      scan_wd_in = scan_wd_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      mk_wd_in   = mk_wd_ff;
      fr_wd_in   = fr_wd_ff;
      fr_bit_in  = fr_bit_ff;
      pend_in    = pend_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctl = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               pend_in.granted_address = '0;
               pend_in.status          = bsa_pkg::STATUS_FAIL;
               len_in   = req_data.run_length;
               state_in = S_RESP;
               unique case (req_data.action)
                  bsa_pkg::ACT_ALLOC: begin
                     if ((req_data.run_length != '0) &&
                         (bsa_pkg::LIM_W'(req_data.run_length) <= limit)) begin
                        ctl.rd_en   = 1'b1;
                        ctl.rd_addr = '0;
                        scan_wd_in  = '0;
                        run_in      = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  bsa_pkg::ACT_FREE: begin
                     if (free_idx < bsa_pkg::ADDR_W'(limit)) begin
                        ctl.rd_en   = 1'b1;
                        ctl.rd_addr = free_idx[bsa_pkg::IDX_W-1:bsa_pkg::WB_W];
                        fr_wd_in    = free_idx[bsa_pkg::IDX_W-1:bsa_pkg::WB_W];
                        fr_bit_in   = free_idx[bsa_pkg::WB_W-1:0];
                        state_in    = S_FREE;
                     end
                  end
                  bsa_pkg::ACT_CLEAR: begin
                     ctl.clear      = 1'b1;
                     pend_in.status = bsa_pkg::STATUS_OK;
                  end
                  bsa_pkg::ACT_NONE: begin
                     pend_in.status = bsa_pkg::STATUS_FAIL;
                  end
                  default: begin
                     pend_in.status = bsa_pkg::STATUS_FAIL;
                  end
               endcase
            end
         end
         S_SCAN: begin
            run_in = scan_res.run;
            if (scan_res.found) begin
               end_in      = scan_res.end_idx;
               start_in    = st_wide[bsa_pkg::IDX_W-1:0];
               ctl.rd_en   = 1'b1;
               ctl.rd_addr = st_wide[bsa_pkg::IDX_W-1:bsa_pkg::WB_W];
               mk_wd_in    = st_wide[bsa_pkg::IDX_W-1:bsa_pkg::WB_W];
               state_in    = S_MARK;
            end else if (scan_wd_ff == last_wd) begin
               state_in = S_RESP;
            end else begin
               ctl.rd_en   = 1'b1;
               ctl.rd_addr = scan_wd_ff + bsa_pkg::WORD_AW'(1);
               scan_wd_in  = scan_wd_ff + bsa_pkg::WORD_AW'(1);
            end
         end
         S_MARK: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = mk_wd_ff;
            ctl.wr_data = rd_word & ~mark_mask;
            if (mk_wd_ff == end_ff[bsa_pkg::IDX_W-1:bsa_pkg::WB_W]) begin
               pend_in.granted_address = base_ff +
                  (bsa_pkg::ADDR_W'(start_ff) << bsa_pkg::SECTOR_SHIFT);
               pend_in.status = bsa_pkg::STATUS_OK;
               state_in       = S_RESP;
            end else begin
               ctl.rd_en   = 1'b1;
               ctl.rd_addr = mk_wd_ff + bsa_pkg::WORD_AW'(1);
               mk_wd_in    = mk_wd_ff + bsa_pkg::WORD_AW'(1);
            end
         end
         S_FREE: begin
            ctl.wr_en      = 1'b1;
            ctl.wr_addr    = fr_wd_ff;
            ctl.wr_data    = rd_word | (bsa_pkg::WORD_W'(1) << fr_bit_ff);
            pend_in.status = bsa_pkg::STATUS_OK;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         count_ff     <= bsa_pkg::SECTOR_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      run_ff      <= run_in;
      scan_wd_ff  <= scan_wd_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      mk_wd_ff    <= mk_wd_in;
      fr_wd_ff    <= fr_wd_in;
      fr_bit_ff   <= fr_bit_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_rw_same_word: assert property (@(posedge clock) disable iff (reset)
      !(ctl.wr_en && ctl.rd_en && (ctl.wr_addr == ctl.rd_addr)))
      else $error("map read and write hit the same word");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> (rsp_data.granted_address == '0))
      else $error("failed beat carries a nonzero address");

   a_scan_in_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_wd_ff <= last_wd))
      else $error("scan ran past the sectors in use");

   a_mark_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |->
         ((mk_wd_ff <= end_ff[bsa_pkg::IDX_W-1:bsa_pkg::WB_W]) &&
          (mk_wd_ff >= start_ff[bsa_pkg::IDX_W-1:bsa_pkg::WB_W])))
      else $error("mark pass left the granted run");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> (state_ff == S_RESP))
      else $error("clear did not go straight to the result");

endmodule

/* hw/rtl/bsa_map_ram.sv */
// Free-map word memory with per-word valid bits; invalid words read as all free.
`timescale 1ns / 1ps

module bsa_map_ram (
   input  logic                          clock,
   input  logic                          reset,
   input  bsa_pkg::ram_ctl_type          ctl,
   output logic [bsa_pkg::WORD_W-1:0]    rd_word
);

   logic [bsa_pkg::WORD_W-1:0] mem [bsa_pkg::WORDS];
   logic [bsa_pkg::WORDS-1:0]  valid_ff;
   logic [bsa_pkg::WORDS-1:0]  valid_in;
   logic [bsa_pkg::WORD_W-1:0] rd_data_ff;
   logic                       rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= mem[ctl.rd_addr];
         rd_valid_ff <= valid_ff[ctl.rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_word = rd_valid_ff ? rd_data_ff : bsa_pkg::ALL_FREE;

endmodule

/* hw/rtl/bsa_run_scan.sv */
// One-word step of the first-fit search: extends the free run across one map word.
`timescale 1ns / 1ps

module bsa_run_scan (
   input  logic [bsa_pkg::WORD_W-1:0]  word,
   input  logic [bsa_pkg::WORD_AW-1:0] word_idx,
   input  logic [bsa_pkg::LEN_W-1:0]   run_in,
   input  logic [bsa_pkg::LEN_W-1:0]   len,
   input  logic [bsa_pkg::LIM_W-1:0]   limit,
   output bsa_pkg::scan_res_type       res
);

   always_comb begin
      logic [bsa_pkg::IDX_W-1:0] bit_idx;
      logic [bsa_pkg::LEN_W-1:0] run;
      logic                      found;
      logic [bsa_pkg::IDX_W-1:0] end_idx;
      run     = run_in;
      found   = 1'b0;
      end_idx = '0;
      bit_idx = '0;
      for (int k = 0; k < bsa_pkg::WORD_W; k++) begin
         bit_idx = {word_idx, bsa_pkg::WB_W'(k)};
         if (word[k] && (bsa_pkg::LIM_W'(bit_idx) < limit)) begin
            run = run + bsa_pkg::LEN_W'(1);
         end else begin
            run = '0;
         end
         if (!found && (run == len)) begin
            found   = 1'b1;
            end_idx = bit_idx;
         end
      end
      res.found   = found;
      res.end_idx = end_idx;
      res.run     = run;
   end

endmodule

/* dv/bitmap_sector_allocator_tb.sv */
// Testbench for the bitmap sector allocator: directed corner cases, then random request traffic.
`timescale 1ns / 1ps

module bitmap_sector_allocator_tb;

   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned DRAIN_CYCLES = 300;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   bsa_pkg::req_type           req_data    = '0;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   bsa_pkg::rsp_type           rsp_data;
   logic                       csr_wr_en   = 1'b0;
   logic                       csr_index   = bsa_pkg::CSR_BASE;
   logic [bsa_pkg::ADDR_W-1:0] csr_wr_data = '0;

   bit   [bsa_pkg::SECTORS-1:0] free_bits = '1;
   logic [bsa_pkg::ADDR_W-1:0]  base_q    = '0;
   logic [bsa_pkg::CNT_W-1:0]   count_q   = bsa_pkg::SECTOR_COUNT_RESET;
   bsa_pkg::rsp_type            expected_grants[$];
   logic [bsa_pkg::ADDR_W-1:0]  held_sectors[$];

   int unsigned idle_pct    = 0;
   int unsigned stall_pct   = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatches  = 0;

   bitmap_sector_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int unsigned usable_sectors();
      return (count_q < bsa_pkg::SECTORS) ? count_q : bsa_pkg::SECTORS;
   endfunction

   function automatic bsa_pkg::rsp_type predict_grant(input bsa_pkg::req_type r);
      bsa_pkg::rsp_type           res;
      int unsigned                span;
      int unsigned                run;
      int unsigned                start;
      logic [bsa_pkg::ADDR_W-1:0] offset;
      bit                         found;
      span  = usable_sectors();
      run   = 0;
      start = 0;
      found = 1'b0;
      res.granted_address = '0;
      res.status          = bsa_pkg::STATUS_FAIL;
      case (r.action)
         bsa_pkg::ACT_ALLOC: begin
            if (r.run_length != 0 && r.run_length <= span) begin
               for (int k = 0; k < span && !found; k++) begin
                  if (free_bits[k]) begin
                     run++;
                     if (run == r.run_length) begin
                        found = 1'b1;
                        start = k + 1 - run;
                     end
                  end else begin
                     run = 0;
                  end
               end
            end
            if (found) begin
               for (int k = 0; k < r.run_length; k++) begin
                  free_bits[start + k] = 1'b0;
                  held_sectors.push_back(base_q + (start + k) * bsa_pkg::SECTOR_SIZE);
               end
               res.granted_address = base_q + start * bsa_pkg::SECTOR_SIZE;
               res.status          = bsa_pkg::STATUS_OK;
            end
         end
         bsa_pkg::ACT_FREE: begin
            offset = r.address - base_q;
            if (offset / bsa_pkg::SECTOR_SIZE < span) begin
               free_bits[offset / bsa_pkg::SECTOR_SIZE] = 1'b1;
               res.status = bsa_pkg::STATUS_OK;
            end
         end
         bsa_pkg::ACT_CLEAR: begin
            free_bits = '1;
            held_sectors.delete();
            res.status = bsa_pkg::STATUS_OK;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : check_results
      bsa_pkg::rsp_type want;
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_grants.size() == 0) begin
            $error("rsp_data: expected no beat, got %h", rsp_data);
            mismatches++;
         end else begin
            want = expected_grants.pop_front();
            if (rsp_data.granted_address !== want.granted_address) begin
               $error("granted_address: expected %h, got %h",
                      want.granted_address, rsp_data.granted_address);
               mismatches++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %b, got %b", want.status, rsp_data.status);
               mismatches++;
            end
         end
      end
   end

   task automatic send_request(input logic [1:0] action,
                               input logic [bsa_pkg::LEN_W-1:0] len,
                               input logic [bsa_pkg::ADDR_W-1:0] addr);
      bsa_pkg::req_type item;
      item.action     = action;
      item.run_length = len;
      item.address    = addr;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      expected_grants.push_back(predict_grant(item));
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic wait_drained(input int unsigned settle);
      req_valid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [bsa_pkg::ADDR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == bsa_pkg::CSR_BASE) begin
         base_q = value;
         held_sectors.delete();
      end else begin
         count_q = value[bsa_pkg::CNT_W-1:0];
      end
      @(posedge clock);
   endtask

   task automatic test_alloc_limits();
      write_register(bsa_pkg::CSR_BASE, '0);
      write_register(bsa_pkg::CSR_COUNT, bsa_pkg::SECTOR_COUNT_RESET);
      send_request(bsa_pkg::ACT_ALLOC, 0, '0);
      send_request(bsa_pkg::ACT_ALLOC, 1024, '0);
      send_request(bsa_pkg::ACT_ALLOC, 1, '0);
      send_request(bsa_pkg::ACT_FREE, 0, 5 * bsa_pkg::SECTOR_SIZE + 123);
      send_request(bsa_pkg::ACT_ALLOC, 2, '0);
      send_request(bsa_pkg::ACT_ALLOC, 1, '0);
      send_request(bsa_pkg::ACT_ALLOC, 1025, '0);
      send_request(bsa_pkg::ACT_ALLOC, 11'h7FF, '0);
      wait_drained(8);
   endtask

   task automatic test_free_cases();
      send_request(bsa_pkg::ACT_FREE, 0, 32'hFFFF_FFFF);
      send_request(bsa_pkg::ACT_CLEAR, 0, '0);
      send_request(bsa_pkg::ACT_FREE, 0, 3 * bsa_pkg::SECTOR_SIZE);
      send_request(bsa_pkg::ACT_NONE, 11'h7FF, 32'hFFFF_FFFF);
      send_request(bsa_pkg::ACT_ALLOC, 3, '0);
      send_request(bsa_pkg::ACT_FREE, 0, bsa_pkg::SECTOR_SIZE);
      wait_drained(8);
   endtask

   task automatic test_address_wrap();
      write_register(bsa_pkg::CSR_BASE, 32'hFFFF_E000);
      write_register(bsa_pkg::CSR_COUNT, 11'd8);
      send_request(bsa_pkg::ACT_CLEAR, 0, '0);
      send_request(bsa_pkg::ACT_ALLOC, 2, '0);
      send_request(bsa_pkg::ACT_ALLOC, 1, '0);
      send_request(bsa_pkg::ACT_FREE, 0, 32'h0000_0FFF);
      send_request(bsa_pkg::ACT_FREE, 0, 32'hFFFF_DFFF);
      send_request(bsa_pkg::ACT_ALLOC, 6, '0);
      send_request(bsa_pkg::ACT_ALLOC, 9, '0);
      wait_drained(8);
      write_register(bsa_pkg::CSR_BASE, 32'hFFFF_FFFF);
      send_request(bsa_pkg::ACT_CLEAR, 0, '0);
      send_request(bsa_pkg::ACT_ALLOC, 1, '0);
      wait_drained(8);
   endtask

   task automatic test_sector_count_bounds();
      write_register(bsa_pkg::CSR_COUNT, '0);
      send_request(bsa_pkg::ACT_ALLOC, 1, '0);
      send_request(bsa_pkg::ACT_FREE, 0, base_q);
      wait_drained(8);
      write_register(bsa_pkg::CSR_COUNT, 11'h7FF);
      send_request(bsa_pkg::ACT_ALLOC, 1024, '0);
      send_request(bsa_pkg::ACT_FREE, 0, base_q + 1023 * bsa_pkg::SECTOR_SIZE);
      send_request(bsa_pkg::ACT_FREE, 0, base_q + 1024 * bsa_pkg::SECTOR_SIZE);
      wait_drained(8);
   endtask

   task automatic test_random_traffic(input int unsigned items, input int unsigned idle,
                                      input int unsigned stall,
                                      input logic [bsa_pkg::ADDR_W-1:0] base,
                                      input logic [bsa_pkg::CNT_W-1:0] count);
      int unsigned                pick;
      int unsigned                span;
      int unsigned                slot;
      logic [bsa_pkg::ADDR_W-1:0] addr;
      logic [bsa_pkg::LEN_W-1:0]  len;
      wait_drained(8);
      write_register(bsa_pkg::CSR_BASE, base);
      write_register(bsa_pkg::CSR_COUNT, count);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (items) begin
         pick = $urandom_range(99);
         span = usable_sectors();
         if (pick < 45) begin
            case ($urandom_range(19))
               0:          len = bsa_pkg::LEN_W'($urandom_range(2047));
               1, 2, 3:    len = bsa_pkg::LEN_W'($urandom_range(1, (span == 0) ? 1 : span));
               4, 5, 6, 7: len = bsa_pkg::LEN_W'($urandom_range(1, 32));
               default:    len = bsa_pkg::LEN_W'($urandom_range(1, 4));
            endcase
            send_request(bsa_pkg::ACT_ALLOC, len, $urandom);
         end else if (pick < 85) begin
            if (held_sectors.size() != 0 && $urandom_range(4) != 0) begin
               slot = $urandom_range(held_sectors.size() - 1);
               addr = held_sectors[slot] + $urandom_range(bsa_pkg::SECTOR_SIZE - 1);
               held_sectors.delete(slot);
            end else begin
               addr = base_q + $urandom_range(span + 8) * bsa_pkg::SECTOR_SIZE
                      + $urandom_range(bsa_pkg::SECTOR_SIZE - 1);
            end
            send_request(bsa_pkg::ACT_FREE, bsa_pkg::LEN_W'($urandom), addr);
         end else if (pick < 93) begin
            send_request(bsa_pkg::ACT_FREE, bsa_pkg::LEN_W'($urandom), $urandom);
         end else if (pick < 97) begin
            send_request(bsa_pkg::ACT_CLEAR, bsa_pkg::LEN_W'($urandom), $urandom);
         end else begin
            send_request(bsa_pkg::ACT_NONE, bsa_pkg::LEN_W'($urandom), $urandom);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset     <= 1'b0;
      idle_pct  = 37;
      stall_pct = 37;
      test_alloc_limits();
      test_free_cases();
      test_address_wrap();
      test_sector_count_bounds();
      test_random_traffic(225, 0, 0, '0, bsa_pkg::SECTOR_COUNT_RESET);
      test_random_traffic(225, 87, 0, $urandom & 32'hFFFF_F000, 11'd64);
      test_random_traffic(225, 0, 87, $urandom, 11'd8);
      test_random_traffic(225, 37, 37, 32'hFFFF_C000, 11'h7FF);
      test_random_traffic(225, 0, 0, $urandom,
                          bsa_pkg::CNT_W'($urandom_range(1, bsa_pkg::SECTORS)));
      wait_drained(DRAIN_CYCLES);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
